@@ sv/tre_pkg.sv @@
`timescale 1ns / 1ps

package tre_pkg;

  // Offset counter width; run_start carries its low FIELD_W bits
  localparam int OFFSET_BITS = 48;
  localparam int FIELD_W     = 48;
  localparam int MINLEN_W    = 13;
  localparam int DATA_W      = 48;
  localparam int INDEX_W     = 2;

  // Depth of the queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [FIELD_W-1:0] RUN_MAX = {FIELD_W{1'b1}};

  // Scan modes
  localparam logic [1:0] MODE_PRINTABLE = 2'd0;
  localparam logic [1:0] MODE_ALNUM     = 2'd1;
  localparam logic [1:0] MODE_TEXT      = 2'd2;
  localparam logic [1:0] MODE_IDENT     = 2'd3;

  // Opcodes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_SCAN_MODE    = 2'd0;
  localparam logic [INDEX_W-1:0] REG_INCLUDE_WS   = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MIN_LENGTH   = 2'd2;
  localparam logic [INDEX_W-1:0] REG_START_OFFSET = 2'd3;

  // Byte constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] run_start;
    logic [FIELD_W-1:0] run_length;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          scan_mode;
    logic                include_whitespace;
    logic [MINLEN_W-1:0] min_length;
    logic [FIELD_W-1:0]  start_offset;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic is_end;
    logic ok_first;
    logic ok_rest;
    logic is_nul;
  } cls_t;

endpackage

@@ sv/tre_front.sv @@
`timescale 1ns / 1ps

module tre_front import tre_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     push,
  output cls_t     push_cls,
  input  logic     q_full
);

  logic [7:0] c;
  logic       digit, letter, blank, printable, text;
  logic       ok;

  assign c = in_item.data_byte;

  // Byte class tests
  always_comb begin
    digit     = (c >= 8'h30) && (c <= 8'h39);
    letter    = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    blank     = (c == CH_SPACE) || (c == CH_TAB);
    printable = (c >= CH_SPACE) && (c <= CH_TILDE);
    text      = (c >= CH_BANG) && (c <= CH_TILDE);
  end

  // Select acceptance by mode
  always_comb begin
    ok = printable;
    push_cls.ok_first = 1'b0;
    push_cls.ok_rest  = 1'b0;
    unique case (cfg.scan_mode)
      MODE_PRINTABLE: ok = printable;
      MODE_ALNUM:     ok = letter || digit || (cfg.include_whitespace && blank);
      MODE_TEXT:      ok = cfg.include_whitespace ? (printable || blank) : text;
      MODE_IDENT:     ok = 1'b0;
      default:        ok = printable;
    endcase
    if (cfg.scan_mode == MODE_IDENT) begin
      push_cls.ok_first = (c == CH_UNDER) || letter;
      push_cls.ok_rest  = (c == CH_UNDER) || letter || digit;
    end else begin
      push_cls.ok_first = ok;
      push_cls.ok_rest  = ok;
    end
    push_cls.is_end = (in_item.opcode == OP_END);
    push_cls.is_nul = (c == CH_NUL);
  end

  // Accept whenever the queue has room, except during reset and while rst_hold is set
  logic rst_hold;
  always_ff @(posedge clk) begin
    rst_hold <= rst;
  end

  assign in_stall = q_full || rst || rst_hold;
  assign push     = in_valid && !in_stall;

endmodule

@@ sv/tre_queue.sv @@
`timescale 1ns / 1ps

module tre_queue import tre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_cls,
  output logic full,
  output logic not_empty,
  output cls_t head,
  input  logic pop
);

  cls_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cls;
    end
  end

endmodule

@@ sv/tre_back.sv @@
`timescale 1ns / 1ps

module tre_back import tre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      load_offset,
  input  logic [FIELD_W-1:0] load_value,
  input  logic      q_not_empty,
  input  cls_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [OFFSET_BITS-1:0] byte_offset;
  logic [FIELD_W-1:0]     cur_start;
  logic [FIELD_W-1:0]     cur_len;

  logic [FIELD_W-1:0] need;
  logic               run_open;
  logic               ok;
  logic               long_enough;
  logic               terminated;
  logic               report;

  // Take the next item whenever the output slot is free or draining
  assign pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    need        = (cfg.min_length == '0) ? FIELD_W'(1) : FIELD_W'(cfg.min_length);
    run_open    = (cur_len != '0);
    ok          = run_open ? q_head.ok_rest : q_head.ok_first;
    long_enough = run_open && (cur_len >= need);
    terminated  = (cfg.scan_mode != MODE_IDENT) || (!q_head.is_end && q_head.is_nul);
    report      = pop && long_enough && terminated && (q_head.is_end || !ok);
  end

  // Update run state and offset
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      cur_len     <= '0;
      cur_start   <= '0;
    end else if (load_offset) begin
      byte_offset <= OFFSET_BITS'(load_value);
      cur_len     <= '0;
    end else if (pop) begin
      if (q_head.is_end) begin
        cur_len     <= '0;
        byte_offset <= OFFSET_BITS'(cfg.start_offset);
      end else begin
        byte_offset <= byte_offset + 1'b1;
        if (ok) begin
          if (!run_open) begin
            cur_start <= FIELD_W'(byte_offset);
          end
          if (cur_len != RUN_MAX) begin
            cur_len <= cur_len + 1'b1;
          end
        end else begin
          cur_len <= '0;
        end
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= report;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      out_item.run_start  <= cur_start;
      out_item.run_length <= cur_len;
    end
  end

endmodule

@@ sv/text_run_extractor.sv @@
`timescale 1ns / 1ps

// Text run extractor: scans a file byte stream and reports each run of accepted
// bytes (printable, alphanumeric, ASCII text or C identifier, chosen by
// scan_mode) that reaches min_length, as its start offset and length. A run is
// reported when a rejected byte or the end marker closes it; identifier runs
// count only when a NUL byte ends them. The block takes one item per clock:
// while the queue has room: the front classifies each byte combinationally,
// a two-entry queue decouples it from the run tracker, and the tracker
// retires one item per cycle into an output register while not stalled,
// so a stalled result holds back intake only once the queue fills. Write
// configuration only while the block is idle; writing start_offset drops any
// open run and restarts the offset count.
module text_run_extractor import tre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]  wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item
);

  cfg_t cfg;
  logic push, q_full, q_not_empty, pop;
  cls_t push_cls, q_head;
  logic load_offset;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode          <= MODE_ALNUM;
      cfg.include_whitespace <= 1'b1;
      cfg.min_length         <= MINLEN_W'(4);
      cfg.start_offset       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCAN_MODE:    cfg.scan_mode          <= wr_data[1:0];
        REG_INCLUDE_WS:   cfg.include_whitespace <= wr_data[0];
        REG_MIN_LENGTH:   cfg.min_length         <= wr_data[MINLEN_W-1:0];
        REG_START_OFFSET: cfg.start_offset       <= wr_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign load_offset = wr_en && (wr_index == REG_START_OFFSET);

  tre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_cls (push_cls),
    .q_full   (q_full)
  );

  tre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cls  (push_cls),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (pop)
  );

  tre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load_offset (load_offset),
    .load_value  (wr_data[FIELD_W-1:0]),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
